/* rtl/q_learning_victim_select_core_macros.svh */
// assertion macros for the q-learning victim select core
// used by files that check their own logic; expects clk and arst_n in scope
`ifndef Q_LEARNING_VICTIM_SELECT_CORE_MACROS_SVH
`define Q_LEARNING_VICTIM_SELECT_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define QLVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define QLVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/qlvs_pkg.sv */
// shared types and constants for the q-learning victim select core
// no dependencies
package qlvs_pkg;

	localparam int LINES_DEF = 16;
	localparam int MASK_BITS = 16;
	localparam int Q_W = 16;
	localparam int CFG_W = 8;

	localparam logic [7:0] LEARN_RATE_RST = 8'd26;
	localparam logic [7:0] DISCOUNT_RST = 8'd230;
	localparam logic [7:0] EXPLORE_RATE_RST = 8'd26;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_LEARN_RATE = 2'd0;
	localparam logic [1:0] REG_DISCOUNT = 2'd1;
	localparam logic [1:0] REG_EXPLORE_RATE = 2'd2;

	// +1.0 and -1.0 in q7.8
	localparam logic signed [18:0] REWARD_POS = 19'sd256;
	localparam logic signed [18:0] REWARD_NEG = -19'sd256;

	localparam logic signed [19:0] Q_SAT_MAX = 20'sd32767;
	localparam logic signed [19:0] Q_SAT_MIN = -20'sd32768;

	typedef struct packed {
		logic [15:0] valid_mask;
		logic [7:0]  explore_draw;
		logic [3:0]  random_line;
	} in_item_t;

	typedef struct packed {
		logic [3:0] victim_line;
		logic       explored;
	} out_item_t;

	typedef struct packed {
		logic [7:0] learn_rate;
		logic [7:0] discount;
		logic [7:0] explore_rate;
	} cfg_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic count;
		logic scan;
		logic mul1;
		logic tgt;
		logic mul2;
		logic write;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_last;
	} sts_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_SCAN,
		ST_DRAIN,
		ST_MUL1,
		ST_TGT,
		ST_MUL2,
		ST_WRITE
	} state_t;

endpackage

/* rtl/q_learning_victim_select_core.sv */
// top level of the q-learning victim select core
// depends on qlvs_pkg, qlvs_regs, qlvs_ctrl, qlvs_dp and the macros header
//
// usage:
//   request channel: drive req and raise start; the request transfers at a
//   clock edge where start is high and busy is low.
//   result channel: done is high for exactly one cycle with result holding
//   the victim line and the explored flag; the receiver cannot stall it.
//   config: apb-style port, learn_rate at 0x0, discount at 0x4, explore_rate
//   at 0x8, 8 bits each; pready is always high. write only while idle.
// requests: the core works on one request at a time; a new request can
//   transfer in the cycle done is high. the row scan is paced by the single
//   read port of the q table, which delivers one entry of the row per cycle.
// reset: registers return to defaults and busy stays high while a clearing
//   pass zeroes the q table one entry per cycle.
`include "q_learning_victim_select_core_macros.svh"

module q_learning_victim_select_core #(
	parameter int LINES = qlvs_pkg::LINES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  qlvs_pkg::in_item_t            req,
	output logic                          done,
	output qlvs_pkg::out_item_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qlvs_pkg::PADDR_W-1:0]  paddr,
	input  logic [qlvs_pkg::PDATA_W-1:0]  pwdata,
	output logic [qlvs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	qlvs_pkg::cfg_t cfg;
	qlvs_pkg::cmd_t cmd;
	qlvs_pkg::sts_t sts;

	assign pready = 1'b1;

	qlvs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	qlvs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	qlvs_dp #(
		.LINES (LINES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.cfg    (cfg),
		.done   (done),
		.result (result)
	);

	`QLVS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request transfer did not start work")
	`QLVS_ASSERT_NEXT(a_idle_no_done, !busy, !done, "result strobe without work in flight")
	`QLVS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`QLVS_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still working")

endmodule

/* rtl/qlvs_regs.sv */
// configuration registers behind the apb-style port
// depends on qlvs_pkg
module qlvs_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qlvs_pkg::PADDR_W-1:0]  paddr,
	input  logic [qlvs_pkg::PDATA_W-1:0]  pwdata,
	output logic [qlvs_pkg::PDATA_W-1:0]  prdata,
	output qlvs_pkg::cfg_t                cfg
);

	qlvs_pkg::cfg_t cfg_q;
	logic [1:0] idx;
	logic wr_en;

	assign idx = paddr[3:2];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_rate <= qlvs_pkg::LEARN_RATE_RST;
			cfg_q.discount <= qlvs_pkg::DISCOUNT_RST;
			cfg_q.explore_rate <= qlvs_pkg::EXPLORE_RATE_RST;
		end else if (wr_en) begin
			// unknown index: write dropped
			unique case (idx)
				qlvs_pkg::REG_LEARN_RATE: cfg_q.learn_rate <= pwdata[7:0];
				qlvs_pkg::REG_DISCOUNT: cfg_q.discount <= pwdata[7:0];
				qlvs_pkg::REG_EXPLORE_RATE: cfg_q.explore_rate <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			qlvs_pkg::REG_LEARN_RATE: prdata = {24'd0, cfg_q.learn_rate};
			qlvs_pkg::REG_DISCOUNT: prdata = {24'd0, cfg_q.discount};
			qlvs_pkg::REG_EXPLORE_RATE: prdata = {24'd0, cfg_q.explore_rate};
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/qlvs_ctrl.sv */
// sequencer for the victim select core: clear pass, row scan, update
// depends on qlvs_pkg
module qlvs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  qlvs_pkg::sts_t  sts,
	output qlvs_pkg::cmd_t  cmd
);

	qlvs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qlvs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			qlvs_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = qlvs_pkg::ST_IDLE;
			end
			qlvs_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = qlvs_pkg::ST_COUNT;
				end
			end
			qlvs_pkg::ST_COUNT: begin
				cmd.count = 1'b1;
				state_d = qlvs_pkg::ST_SCAN;
			end
			qlvs_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) state_d = qlvs_pkg::ST_DRAIN;
			end
			// last read data lands here
			qlvs_pkg::ST_DRAIN: state_d = qlvs_pkg::ST_MUL1;
			qlvs_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = qlvs_pkg::ST_TGT;
			end
			qlvs_pkg::ST_TGT: begin
				cmd.tgt = 1'b1;
				state_d = qlvs_pkg::ST_MUL2;
			end
			qlvs_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = qlvs_pkg::ST_WRITE;
			end
			qlvs_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
				state_d = qlvs_pkg::ST_IDLE;
			end
			default: state_d = qlvs_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != qlvs_pkg::ST_IDLE);

endmodule

/* rtl/qlvs_dp.sv */
// datapath: q table memory, row scan for the maximum, q update arithmetic
// depends on qlvs_pkg
module qlvs_dp #(
	parameter int LINES = qlvs_pkg::LINES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qlvs_pkg::cmd_t       cmd,
	output qlvs_pkg::sts_t       sts,
	input  qlvs_pkg::in_item_t   req,
	input  qlvs_pkg::cfg_t       cfg,
	output logic                 done,
	output qlvs_pkg::out_item_t  result
);

	localparam int DEPTH = (LINES + 1) * LINES;
	localparam int AW = $clog2(DEPTH);
	localparam int VW = $clog2(LINES);
	localparam int OW = $clog2(LINES + 1);

	logic signed [15:0] mem [DEPTH];

	logic [AW-1:0] clr_cnt_q;
	logic [VW-1:0] scan_cnt_q;
	logic [15:0]   mask_q;
	logic          explore_q;
	logic [VW-1:0] exp_line_q;
	logic [AW-1:0] base_q;

	logic                 rd_vld_s1;
	logic [VW-1:0]        rd_line_s1;
	logic signed [15:0]   rdata_s1;

	logic signed [15:0]   best_q;
	logic [VW-1:0]        best_idx_q;
	logic signed [15:0]   exp_val_q;

	logic [VW-1:0]        victim_q;
	logic signed [15:0]   old_q;
	logic signed [24:0]   prod1_q;
	logic signed [18:0]   diff_q;
	logic signed [27:0]   prod2_q;

	logic                 done_q;
	qlvs_pkg::out_item_t  result_q;

	logic [OW-1:0]        occ;
	logic [VW-1:0]        rnd_line;
	logic [VW+3:0]        victim_x;
	logic                 victim_valid;
	logic signed [18:0]   target;
	logic signed [19:0]   next_q;
	logic signed [15:0]   sat_q;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic signed [15:0]   wdata;

	// valid lines among those the mask covers
	always_comb begin
		occ = '0;
		for (int i = 0; i < qlvs_pkg::MASK_BITS; i++) begin
			if (i < LINES) occ = occ + OW'(mask_q[i]);
		end
	end

	// random line folded into range
	always_comb begin
		rnd_line = '0;
		for (int v = 0; v < 16; v++) begin
			if (req.random_line == 4'(v)) rnd_line = VW'(v % LINES);
		end
	end

	// lines at index 16 and up count as invalid
	assign victim_x = {4'd0, victim_q};
	assign victim_valid = (victim_x < (VW + 4)'(qlvs_pkg::MASK_BITS)) && mask_q[victim_x[3:0]];

	assign target = 19'($signed(prod1_q[24:8])) + (victim_valid ? qlvs_pkg::REWARD_NEG
		: qlvs_pkg::REWARD_POS);
	assign next_q = 20'(old_q) + prod2_q[27:8];

	always_comb begin
		if (next_q > qlvs_pkg::Q_SAT_MAX) sat_q = 16'sh7fff;
		else if (next_q < qlvs_pkg::Q_SAT_MIN) sat_q = -16'sh8000;
		else sat_q = next_q[15:0];
	end

	assign we = cmd.clr_step | cmd.write;
	assign waddr = cmd.clr_step ? clr_cnt_q : base_q + AW'(victim_q);
	assign wdata = cmd.clr_step ? '0 : sat_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.scan) rdata_s1 <= mem[base_q + AW'(scan_cnt_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			scan_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (cmd.count) scan_cnt_q <= '0;
			else if (cmd.scan) scan_cnt_q <= scan_cnt_q + VW'(1);
			rd_vld_s1 <= cmd.scan;
			done_q <= cmd.write;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mask_q <= req.valid_mask;
			explore_q <= req.explore_draw < cfg.explore_rate;
			exp_line_q <= rnd_line;
		end
		if (cmd.count) base_q <= AW'(occ * LINES);
		if (cmd.scan) rd_line_s1 <= scan_cnt_q;
		if (rd_vld_s1) begin
			// strict compare keeps the first maximum
			if (rd_line_s1 == '0 || rdata_s1 > best_q) begin
				best_q <= rdata_s1;
				best_idx_q <= rd_line_s1;
			end
			if (rd_line_s1 == exp_line_q) exp_val_q <= rdata_s1;
		end
		if (cmd.mul1) begin
			prod1_q <= $signed({1'b0, cfg.discount}) * best_q;
			victim_q <= explore_q ? exp_line_q : best_idx_q;
			old_q <= explore_q ? exp_val_q : best_q;
		end
		if (cmd.tgt) diff_q <= target - 19'(old_q);
		if (cmd.mul2) prod2_q <= $signed({1'b0, cfg.learn_rate}) * diff_q;
		if (cmd.write) begin
			result_q.victim_line <= victim_x[3:0];
			result_q.explored <= explore_q;
		end
	end

	assign sts.clr_last = (clr_cnt_q == AW'(DEPTH - 1));
	assign sts.scan_last = (scan_cnt_q == VW'(LINES - 1));
	assign done = done_q;
	assign result = result_q;

endmodule

/* tb/q_learning_victim_select_core_tb.sv */
// testbench for q_learning_victim_select_core: a directed table, then random requests,
// checked against the table's expected results or a q-table predictor kept in the bench
// depends on qlvs_pkg and the core rtl
module q_learning_victim_select_core_tb;

	localparam int N_LINES = 16;
	localparam int N_STATES = N_LINES + 1;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int SHOWN_ERRORS = 10;
	localparam int N_DIR = 25;

	localparam longint Q_TOP = 32767;
	localparam longint Q_BOTTOM = -32768;
	localparam longint REWARD = 256;

	localparam logic [3:0] ADDR_LR = {qlvs_pkg::REG_LEARN_RATE, 2'b00};
	localparam logic [3:0] ADDR_GAMMA = {qlvs_pkg::REG_DISCOUNT, 2'b00};
	localparam logic [3:0] ADDR_EPS = {qlvs_pkg::REG_EXPLORE_RATE, 2'b00};
	localparam logic [3:0] ADDR_UNMAPPED = 4'hC;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [3:0]  addr;
		logic [7:0]  wval;
		logic [15:0] mask;
		logic [7:0]  draw;
		logic [3:0]  rline;
		logic        typed;
		logic [3:0]  want_line;
		logic        want_expl;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	qlvs_pkg::in_item_t req = '0;
	logic done;
	qlvs_pkg::out_item_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [qlvs_pkg::PADDR_W-1:0] paddr = '0;
	logic [qlvs_pkg::PDATA_W-1:0] pwdata = '0;
	logic [qlvs_pkg::PDATA_W-1:0] prdata;
	logic pready;

	// predictor state
	logic signed [15:0] q_est [0:N_STATES*N_LINES-1];
	logic [7:0] alpha_est;
	logic [7:0] gamma_est;
	logic [7:0] eps_est;
	qlvs_pkg::out_item_t victim_q [$];

	dir_row_t dir_rows [N_DIR];
	int idle_pct = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_explored = 0;
	int n_sat_hi = 0;
	int n_sat_lo = 0;
	int n_errors = 0;
	logic [N_STATES-1:0] states_hit = '0;
	longint cycles = 0;

	q_learning_victim_select_core #(
		.LINES(N_LINES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	task automatic note_error(input string msg);
		n_errors++;
		if (n_errors <= SHOWN_ERRORS) begin
			$display("%s", msg);
		end
	endtask

	// picks the victim and moves the q entry, as the core should
	function automatic qlvs_pkg::out_item_t pick_victim(input qlvs_pkg::in_item_t it);
		int row;
		int vic;
		logic signed [15:0] best;
		logic signed [15:0] old;
		longint tgt;
		longint nxt;
		qlvs_pkg::out_item_t o;
		row = $countones(it.valid_mask) * N_LINES;
		states_hit[row / N_LINES] = 1'b1;
		best = q_est[row];
		vic = 0;
		for (int l = 1; l < N_LINES; l++) begin
			if (q_est[row + l] > best) begin
				best = q_est[row + l];
				vic = l;
			end
		end
		o.explored = (it.explore_draw < eps_est);
		if (o.explored) begin
			vic = it.random_line;
			n_explored++;
		end
		old = q_est[row + vic];
		// arithmetic shifts give the floor of the divisions by 256
		tgt = ((longint'(gamma_est) * longint'(best)) >>> 8)
			+ (it.valid_mask[vic] ? -REWARD : REWARD);
		nxt = longint'(old) + ((longint'(alpha_est) * (tgt - longint'(old))) >>> 8);
		if (nxt > Q_TOP) begin
			nxt = Q_TOP;
			n_sat_hi++;
		end else if (nxt < Q_BOTTOM) begin
			nxt = Q_BOTTOM;
			n_sat_lo++;
		end
		q_est[row + vic] = 16'(nxt);
		o.victim_line = 4'(vic);
		return o;
	endfunction

	function automatic qlvs_pkg::in_item_t rand_item();
		qlvs_pkg::in_item_t it;
		logic [15:0] a;
		logic [15:0] b;
		a = 16'($urandom);
		b = 16'($urandom);
		// spread the occupancy so every state gets traffic
		case ($urandom_range(0, 5))
			0: it.valid_mask = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1: it.valid_mask = a & b;
			2: it.valid_mask = a | b;
			3: it.valid_mask = a & b & 16'($urandom);
			4: it.valid_mask = a | b | 16'($urandom);
			default: it.valid_mask = a;
		endcase
		if ($urandom_range(0, 3) == 0) begin
			it.explore_draw = eps_est + 8'($urandom_range(0, 2)) - 8'd1;
		end else begin
			it.explore_draw = 8'($urandom);
		end
		it.random_line = 4'($urandom);
		return it;
	endfunction

	// one request transfer; returns at the edge where it is taken
	task automatic send_req(input qlvs_pkg::in_item_t it, input logic typed,
		input qlvs_pkg::out_item_t want);
		qlvs_pkg::out_item_t got;
		logic taken;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		req <= it;
		// busy is looked at mid-cycle, so the edge that takes the request is known
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		got = pick_victim(it);
		victim_q.push_back(typed ? want : got);
		n_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (victim_q.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write followed by a readback of the same address
	task automatic cfg_write(input logic [3:0] addr, input logic [7:0] val);
		logic [7:0] held;
		logic mapped;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mapped = 1'b1;
		held = 8'h00;
		case (addr[3:2])
			qlvs_pkg::REG_LEARN_RATE: begin
				alpha_est = val;
				held = val;
			end
			qlvs_pkg::REG_DISCOUNT: begin
				gamma_est = val;
				held = val;
			end
			qlvs_pkg::REG_EXPLORE_RATE: begin
				eps_est = val;
				held = val;
			end
			default: mapped = 1'b0;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (mapped && prdata[7:0] !== held) begin
			note_error($sformatf("readback at 0x%h: expected %0d, got %0d",
				addr, held, prdata[7:0]));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] alpha, input logic [7:0] gamma_v,
		input logic [7:0] eps, input int idle, input int n);
		wait_drained();
		cfg_write(ADDR_LR, alpha);
		cfg_write(ADDR_GAMMA, gamma_v);
		cfg_write(ADDR_EPS, eps);
		idle_pct = idle;
		repeat (n) send_req(rand_item(), 1'b0, '0);
	endtask

	// result checker: every done strobe is one transfer, looked at mid-cycle
	always @(negedge clk) begin
		qlvs_pkg::out_item_t want;
		if (arst_n && done) begin
			if (victim_q.size() == 0) begin
				note_error($sformatf("unexpected result: victim %0d explored %0b",
					result.victim_line, result.explored));
			end else begin
				want = victim_q.pop_front();
				n_checked++;
				if (result.victim_line !== want.victim_line) begin
					note_error($sformatf("result %0d victim_line: expected %0d, got %0d",
						n_checked, want.victim_line, result.victim_line));
				end
				if (result.explored !== want.explored) begin
					note_error($sformatf("result %0d explored: expected %0b, got %0b",
						n_checked, want.explored, result.explored));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				victim_q.size());
			$display("q_learning_victim_select_core_tb: done, errors");
			$finish;
		end
	end

	initial begin
		qlvs_pkg::in_item_t it;
		qlvs_pkg::out_item_t want;
		logic [3:0] hot_line;
		for (int i = 0; i < N_STATES * N_LINES; i++) begin
			q_est[i] = '0;
		end
		alpha_est = qlvs_pkg::LEARN_RATE_RST;
		gamma_est = qlvs_pkg::DISCOUNT_RST;
		eps_est = qlvs_pkg::EXPLORE_RATE_RST;

		dir_rows = '{
			// empty table after reset: greedy pick is line 0
			{ROW_REQ, ADDR_LR, 8'h00, 16'h0000, 8'd255, 4'd5, 1'b1, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'hFFFF, 8'd255, 4'd9, 1'b1, 4'd0, 1'b0},
			// draws below the explore rate take the random line
			{ROW_REQ, ADDR_LR, 8'h00, 16'hFFFF, 8'd0, 4'd15, 1'b1, 4'd15, 1'b1},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h0001, 8'd25, 4'd3, 1'b1, 4'd3, 1'b1},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h8000, 8'd26, 4'd7, 1'b0, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'hAAAA, 8'd128, 4'd0, 1'b1, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h5555, 8'd200, 4'd1, 1'b0, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h0000, 8'd0, 4'd0, 1'b1, 4'd0, 1'b1},
			{ROW_REQ, ADDR_LR, 8'h00, 16'hFFFF, 8'd255, 4'd0, 1'b0, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h7FFF, 8'd255, 4'd4, 1'b1, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'hFFFE, 8'd0, 4'd0, 1'b1, 4'd0, 1'b1},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h1234, 8'h80, 4'hA, 1'b0, 4'd0, 1'b0},
			// explore rate zero: never explores, even on a zero draw
			{ROW_CFG, ADDR_EPS, 8'd0, 16'h0000, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h00FF, 8'd0, 4'd7, 1'b0, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h0000, 8'd0, 4'd15, 1'b0, 4'd0, 1'b0},
			// unmapped address: the write must change nothing
			{ROW_CFG, ADDR_UNMAPPED, 8'hFF, 16'h0000, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'hFFFF, 8'd0, 4'd3, 1'b0, 4'd0, 1'b0},
			// all registers at their top value
			{ROW_CFG, ADDR_LR, 8'd255, 16'h0000, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0},
			{ROW_CFG, ADDR_GAMMA, 8'd255, 16'h0000, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0},
			{ROW_CFG, ADDR_EPS, 8'd255, 16'h0000, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h0000, 8'd254, 4'd6, 1'b1, 4'd6, 1'b1},
			{ROW_REQ, ADDR_LR, 8'h00, 16'h0000, 8'd255, 4'd6, 1'b0, 4'd0, 1'b0},
			// zero learn rate and discount
			{ROW_CFG, ADDR_LR, 8'd0, 16'h0000, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0},
			{ROW_CFG, ADDR_GAMMA, 8'd0, 16'h0000, 8'd0, 4'd0, 1'b0, 4'd0, 1'b0},
			{ROW_REQ, ADDR_LR, 8'h00, 16'hF0F0, 8'd255, 4'd2, 1'b0, 4'd0, 1'b0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// lets the clearing pass finish
		wait_drained();

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_drained();
				cfg_write(dir_rows[i].addr, dir_rows[i].wval);
			end else begin
				it.valid_mask = dir_rows[i].mask;
				it.explore_draw = dir_rows[i].draw;
				it.random_line = dir_rows[i].rline;
				want.victim_line = dir_rows[i].want_line;
				want.explored = dir_rows[i].want_expl;
				send_req(it, dir_rows[i].typed, want);
			end
		end

		run_phase(qlvs_pkg::LEARN_RATE_RST, qlvs_pkg::DISCOUNT_RST,
			qlvs_pkg::EXPLORE_RATE_RST, 0, 140);
		run_phase(8'd255, 8'd255, 8'd128, 73, 140);
		run_phase(8'd0, 8'd0, 8'd255, 26, 140);
		run_phase(8'd128, 8'd64, 8'd0, 0, 140);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 73, 140);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 26, 140);
		run_phase(8'd1, 8'd254, 8'd1, 0, 140);

		// push one entry of the empty-set row up into positive saturation
		wait_drained();
		cfg_write(ADDR_LR, 8'd255);
		cfg_write(ADDR_GAMMA, 8'd255);
		cfg_write(ADDR_EPS, 8'd255);
		idle_pct = 0;
		hot_line = 4'($urandom);
		it.valid_mask = 16'h0000;
		it.explore_draw = 8'd0;
		it.random_line = hot_line;
		repeat (300) send_req(it, 1'b0, '0);

		// full set, greedy: every pick is penalized
		wait_drained();
		cfg_write(ADDR_EPS, 8'd0);
		it.valid_mask = 16'hFFFF;
		repeat (100) begin
			it.explore_draw = 8'($urandom);
			it.random_line = 4'($urandom);
			send_req(it, 1'b0, '0);
		end

		run_phase(qlvs_pkg::LEARN_RATE_RST, qlvs_pkg::DISCOUNT_RST,
			qlvs_pkg::EXPLORE_RATE_RST, 26, 100);
		wait_drained();

		$display("q_learning_victim_select_core_tb: %0d requests, %0d checked, %0d explored",
			n_sent, n_checked, n_explored);
		$display("q_learning_victim_select_core_tb: states %b, clamps %0d/%0d, %0d mismatches",
			states_hit, n_sat_hi, n_sat_lo, n_errors);
		if (n_errors == 0) begin
			$display("q_learning_victim_select_core_tb: done, clean");
		end else begin
			$display("q_learning_victim_select_core_tb: done, errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qlvs_pkg.sv
rtl/qlvs_regs.sv
rtl/qlvs_ctrl.sv
rtl/qlvs_dp.sv
rtl/q_learning_victim_select_core.sv
tb/q_learning_victim_select_core_tb.sv
